/* sv/hcbd_pkg.sv */
// Shared types and constants for the chunked body decoder.
// Used by the channel interfaces' users, the result queue and the top level.
package hcbd_pkg;

  // default width of the byte counters
  localparam int CNT_W_DEF = 16;
  // result queue depth, a power of two of at least 2
  localparam int OFIFO_DEPTH = 4;

  localparam logic [15:0] CAP_RESET = 16'd8192;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // end-of-body status codes
  localparam logic [2:0] ST_ZERO      = 3'd0;
  localparam logic [2:0] ST_ENDED     = 3'd1;
  localparam logic [2:0] ST_CAP       = 3'd2;
  localparam logic [2:0] ST_BAD_DATA  = 3'd3;
  localparam logic [2:0] ST_BAD_EMPTY = 3'd4;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] len;
    logic [2:0]  status;
    logic        last;
  } res_t;

  // up to two results pushed per cycle, slot 1 only with slot 0
  typedef struct packed {
    logic v0;
    logic v1;
    res_t d0;
    res_t d1;
  } push_t;

endpackage

/* sv/hcbd_if.sv */
// Valid/ready channel interfaces for raw body bytes and decoded results.
// Standalone; no package dependency.
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, in_byte, in_last, input ready);
  modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface hcbd_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [15:0] committed_len;
  logic [2:0]  end_status;
  logic        out_last;

  modport source(output valid, out_kind, out_byte, committed_len, end_status, out_last,
                 input ready);
  modport sink(input valid, out_kind, out_byte, committed_len, end_status, out_last,
               output ready);
endinterface

/* sv/http_chunked_body_decoder.sv */
// Chunked body decoder: one raw byte per transaction, results on a queued channel.
// Results are registered in the queue before they reach the output channel.
// Throughput: one byte per cycle while the queue has room; a byte yielding a data
// byte and the summary uses two channel transactions, absorbed by a 4-entry queue.
// Reset (rst_n low, synchronous): parser to size-line start, counts cleared,
// capacity back to 8192, queue emptied.
module http_chunked_body_decoder import hcbd_pkg::*; #(
  parameter int COUNT_WIDTH = CNT_W_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  hcbd_in_if.sink       in_ch,
  hcbd_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata
);

  localparam int AW = COUNT_WIDTH + 1;
  localparam int SW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;

  typedef enum logic [4:0] {
    PH_SIZE = 5'b00001,
    PH_LINE = 5'b00010,
    PH_DATA = 5'b00100,
    PH_CR   = 5'b01000,
    PH_LF   = 5'b10000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [AW-1:0]          acc_r, acc_nxt;
  logic                   saw_r, saw_nxt;
  logic [AW-1:0]          left_r, left_nxt;
  logic [COUNT_WIDTH-1:0] comm_r, comm_nxt;
  logic                   stop_r, stop_nxt;
  logic [2:0]             stat_r, stat_nxt;
  logic [15:0]            cap_r;

  logic                   in_fire;
  logic [7:0]             c;
  logic [7:0]             lc;
  logic                   is_hex;
  logic [3:0]             hex_val;
  logic                   size_path;
  logic                   end_path;
  logic                   data_v;
  logic [SW-1:0]          cap_lim;
  logic [SW-1:0]          mask_ext;
  logic [SW-1:0]          cap_ext;
  logic [AW+3:0]          shifted;
  logic [2:0]             sum_status;
  res_t                   data_res, sum_res;
  push_t                  push;
  res_t                   head;
  logic                   head_v;
  logic                   room;

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && room;
  assign c           = in_ch.in_byte;
  assign lc          = c | 8'h20;

  // decode one hex digit
  always_comb begin
    is_hex  = 1'b0;
    hex_val = 4'd0;
    if (c >= "0" && c <= "9") begin
      is_hex  = 1'b1;
      hex_val = c[3:0];
    end else if (lc >= "a" && lc <= "f") begin
      is_hex  = 1'b1;
      hex_val = 4'(lc[3:0] + 4'd9);
    end
  end

  // capacity clipped to the counter range
  assign cap_ext  = SW'(cap_r);
  assign mask_ext = SW'({COUNT_WIDTH{1'b1}});
  assign cap_lim  = (cap_ext < mask_ext) ? cap_ext : mask_ext;

  // parse one byte and update the body state
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    saw_nxt   = saw_r;
    left_nxt  = left_r;
    comm_nxt  = comm_r;
    stop_nxt  = stop_r;
    stat_nxt  = stat_r;
    size_path = 1'b0;
    end_path  = 1'b0;
    data_v    = 1'b0;
    shifted   = '0;

    if (!stop_r) begin
      unique case (phase_r)
        PH_SIZE: size_path = 1'b1;
        PH_LINE: end_path = (c == CH_LF);
        PH_DATA: begin
          data_v   = 1'b1;
          left_nxt = AW'(left_r - 1'b1);
          if (left_nxt == '0) begin
            comm_nxt  = COUNT_WIDTH'(SW'(comm_r) + SW'(acc_r));
            phase_nxt = PH_CR;
          end
        end
        PH_CR: begin
          phase_nxt = PH_SIZE;
          acc_nxt   = '0;
          saw_nxt   = 1'b0;
          if (c == CH_CR) begin
            phase_nxt = PH_LF;
          end else if (c != CH_LF) begin
            size_path = 1'b1;
          end
        end
        PH_LF: begin
          phase_nxt = PH_SIZE;
          acc_nxt   = '0;
          saw_nxt   = 1'b0;
          size_path = (c != CH_LF);
        end
        default: ;
      endcase
    end

    // size-line byte: gather digit, saturating; else flag an error, end or skip the line
    if (size_path) begin
      shifted = {acc_nxt, hex_val};
      priority if (is_hex) begin
        acc_nxt = (shifted[AW+3:AW] != '0) ? '1 : shifted[AW-1:0];
        saw_nxt = 1'b1;
      end else if (!saw_nxt) begin
        stop_nxt = 1'b1;
        stat_nxt = (comm_r != '0) ? ST_BAD_DATA : ST_BAD_EMPTY;
      end else if (c == CH_LF) begin
        end_path = 1'b1;
      end else begin
        phase_nxt = PH_LINE;
      end
    end

    // size line done: zero chunk, capacity check or start payload
    if (end_path) begin
      priority if (acc_nxt == '0) begin
        stop_nxt = 1'b1;
        stat_nxt = ST_ZERO;
      end else if (SW'(comm_r) + SW'(acc_nxt) > cap_lim) begin
        stop_nxt = 1'b1;
        stat_nxt = ST_CAP;
      end else begin
        phase_nxt = PH_DATA;
        left_nxt  = acc_nxt;
      end
    end
  end

  // status reported on the summary
  always_comb begin
    priority if (stop_nxt) begin
      sum_status = stat_nxt;
    end else if ((phase_nxt == PH_SIZE && saw_nxt && acc_nxt == '0) ||
                 (phase_nxt == PH_LINE && acc_nxt == '0)) begin
      sum_status = ST_ZERO;
    end else begin
      sum_status = ST_ENDED;
    end
  end

  // build result items and pack them into the queue slots
  always_comb begin
    data_res.kind      = KIND_DATA;
    data_res.data_byte = c;
    data_res.len       = 16'(comm_nxt);
    data_res.status    = ST_ZERO;
    data_res.last      = 1'b0;

    sum_res.kind      = KIND_END;
    sum_res.data_byte = 8'd0;
    sum_res.len       = 16'(comm_nxt);
    sum_res.status    = sum_status;
    sum_res.last      = 1'b1;

    push.v0 = in_fire && (data_v || in_ch.in_last);
    push.v1 = in_fire && data_v && in_ch.in_last;
    push.d0 = data_v ? data_res : sum_res;
    push.d1 = sum_res;
  end

  // hold state; return to start of body after the summary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      acc_r   <= '0;
      saw_r   <= 1'b0;
      left_r  <= '0;
      comm_r  <= '0;
      stop_r  <= 1'b0;
      stat_r  <= ST_ZERO;
    end else if (in_fire) begin
      if (in_ch.in_last) begin
        phase_r <= PH_SIZE;
        acc_r   <= '0;
        saw_r   <= 1'b0;
        left_r  <= '0;
        comm_r  <= '0;
        stop_r  <= 1'b0;
        stat_r  <= ST_ZERO;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        saw_r   <= saw_nxt;
        left_r  <= left_nxt;
        comm_r  <= comm_nxt;
        stop_r  <= stop_nxt;
        stat_r  <= stat_nxt;
      end
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  hcbd_out_fifo #(
    .DEPTH (OFIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (head_v && out_ch.ready),
    .head   (head),
    .head_v (head_v),
    .room   (room)
  );

  assign out_ch.valid         = head_v;
  assign out_ch.out_kind      = head.kind;
  assign out_ch.out_byte      = head.data_byte;
  assign out_ch.committed_len = head.len;
  assign out_ch.end_status    = head.status;
  assign out_ch.out_last      = head.last;

  // a last byte always leaves the parser at the start of a fresh body
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.in_last |=> !stop_r && phase_r == PH_SIZE && comm_r == '0)
    else $error("state not cleared after summary");

  // payload phase always has bytes outstanding
  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> left_r != '0)
    else $error("payload phase with no bytes left");

  // data results carry a zero status and no last flag
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_kind == KIND_DATA |-> out_ch.end_status == ST_ZERO &&
      !out_ch.out_last)
    else $error("malformed data result");

endmodule

/* sv/hcbd_out_fifo.sv */
// Result queue: takes up to two results a cycle, hands out one per transaction.
// Depends on hcbd_pkg for res_t and push_t.
module hcbd_out_fifo import hcbd_pkg::*; #(
  parameter int DEPTH = OFIFO_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output res_t  head,
  output logic  head_v,
  output logic  room
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wp_nxt, rp_nxt;
  logic [PW-1:0] wp_inc;

  assign wp_inc = PW'(wp_r + 1'b1);
  assign head   = mem_r[rp_r];
  assign head_v = (count_r != '0);
  // room for a full two-result step, independent of the sink this cycle
  assign room   = (count_r <= CW'(DEPTH - 2));

  // advance pointers and occupancy
  always_comb begin
    wp_nxt    = PW'(wp_r + PW'(push.v0) + PW'(push.v1));
    rp_nxt    = pop ? PW'(rp_r + 1'b1) : rp_r;
    count_nxt = CW'(count_r + CW'(push.v0) + CW'(push.v1) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  // store pushed results
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wp_r] <= push.d0;
    end
    if (push.v1) begin
      mem_r[wp_inc] <= push.d1;
    end
  end

endmodule
